/* rtl/qes_pkg.sv */
// Shared types and constants for the quadratic equation solver pipeline.
// No dependencies.
`default_nettype none
package qes_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int COEF_W = 16;
  localparam int ROOT_W = 34;
  localparam int DISC_W = 34;

  typedef enum logic [2:0] {
    ST_TWO    = 3'd0,
    ST_DOUBLE = 3'd1,
    ST_NONE   = 3'd2,
    ST_LINEAR = 3'd3,
    ST_NOSOL  = 3'd4,
    ST_ALLX   = 3'd5
  } st_t;

  typedef struct packed {
    st_t                       st;
    logic signed [COEF_W-1:0]  a;
    logic signed [COEF_W-1:0]  b;
    logic signed [COEF_W-1:0]  c;
  } meta_t;

endpackage
`default_nettype wire

/* rtl/quadratic_equation_solver.sv */
// Real roots of a*x^2 + b*x + c = 0 in signed fixed point with FRAC_BITS
// fraction bits, plus a status code. Fully pipelined: one coefficient set
// per cycle. The square root and dividers resolve one bit per stage each.
// A stall on the result side holds the whole pipe; nothing is dropped.
// Depends on qes_pkg, qes_disc, qes_sqrt, qes_div.
`default_nettype none
module quadratic_equation_solver #(
  parameter int FRAC_BITS = qes_pkg::FRAC_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output      logic                              in_ready,
  input  wire logic signed [qes_pkg::COEF_W-1:0] coef_a,
  input  wire logic signed [qes_pkg::COEF_W-1:0] coef_b,
  input  wire logic signed [qes_pkg::COEF_W-1:0] coef_c,
  output      logic                              out_valid,
  input  wire logic                              out_ready,
  output      logic [2:0]                        status,
  output      logic signed [qes_pkg::ROOT_W-1:0] root_one,
  output      logic signed [qes_pkg::ROOT_W-1:0] root_two
);
  import qes_pkg::*;

  localparam int SQN = 17 + FRAC_BITS;
  localparam int NUMW = 19 + FRAC_BITS;

  logic              en;
  logic              dv, sv, pv, q1v;
  meta_t             dmeta, smeta;
  logic [DISC_W-1:0] disc;
  logic [SQN-1:0]    sroot;

  logic signed [NUMW-1:0] negb, negc, sx, n1_next, n2_next;
  logic signed [17:0]     den_next;
  logic signed [NUMW-1:0] n1, n2;
  logic signed [17:0]     den;
  logic [2:0]             pst;

  logic signed [ROOT_W-1:0] p, m;
  logic [2:0]               qst;

  assign en = !out_valid || out_ready;
  assign in_ready = en;

  qes_disc u_disc (
    .clk, .rst, .en,
    .in_valid,
    .a(coef_a), .b(coef_b), .c(coef_c),
    .out_valid(dv), .meta(dmeta), .disc
  );

  qes_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
    .clk, .rst, .en,
    .in_valid(dv), .meta_in(dmeta), .disc,
    .out_valid(sv), .meta_out(smeta), .root(sroot)
  );

  always_comb begin
    negb = -($signed({{(NUMW-COEF_W){smeta.b[COEF_W-1]}}, smeta.b}) <<< FRAC_BITS);
    negc = -($signed({{(NUMW-COEF_W){smeta.c[COEF_W-1]}}, smeta.c}) <<< FRAC_BITS);
    sx = $signed({{(NUMW-SQN){1'b0}}, sroot});
    case (smeta.st)
      ST_TWO: begin
        n1_next = negb + sx;
        n2_next = negb - sx;
        den_next = $signed({smeta.a[COEF_W-1], smeta.a, 1'b0});
      end
      ST_DOUBLE: begin
        n1_next = negb;
        n2_next = negb;
        den_next = $signed({smeta.a[COEF_W-1], smeta.a, 1'b0});
      end
      ST_LINEAR: begin
        n1_next = negc;
        n2_next = negc;
        den_next = $signed({{(18-COEF_W){smeta.b[COEF_W-1]}}, smeta.b});
      end
      default: begin
        n1_next = '0;
        n2_next = '0;
        den_next = 18'sd1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) pv <= 1'b0;
    else if (en) pv <= sv;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n1 <= n1_next;
      n2 <= n2_next;
      den <= den_next;
      pst <= smeta.st;
    end
  end

  qes_div #(.FRAC_BITS(FRAC_BITS), .SIDE_W(3)) u_div_p (
    .clk, .rst, .en,
    .in_valid(pv), .num(n1), .den, .side_in(pst),
    .out_valid(q1v), .quot(p), .side_out(qst)
  );

  qes_div #(.FRAC_BITS(FRAC_BITS), .SIDE_W(1)) u_div_m (
    .clk, .rst, .en,
    .in_valid(pv), .num(n2), .den, .side_in(1'b0),
    .out_valid(), .quot(m), .side_out()
  );

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= q1v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      status <= qst;
      root_one <= (p >= m) ? p : m;
      root_two <= (p >= m) ? m : p;
    end
  end

endmodule
`default_nettype wire

/* rtl/qes_disc.sv */
// Discriminant and case classification, two register stages.
// Depends on qes_pkg.
`default_nettype none
module qes_disc (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              en,
  input  wire logic                              in_valid,
  input  wire logic signed [qes_pkg::COEF_W-1:0] a,
  input  wire logic signed [qes_pkg::COEF_W-1:0] b,
  input  wire logic signed [qes_pkg::COEF_W-1:0] c,
  output      logic                              out_valid,
  output      qes_pkg::meta_t                    meta,
  output      logic [qes_pkg::DISC_W-1:0]        disc
);
  import qes_pkg::*;

  logic                      va;
  logic signed [COEF_W-1:0]  a1, b1, c1;
  logic signed [31:0]        bb, ac;
  logic signed [34:0]        d;
  meta_t                     meta_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      va <= in_valid;
      out_valid <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1 <= a;
      b1 <= b;
      c1 <= c;
      bb <= b * b;
      ac <= a * c;
    end
  end

  always_comb begin
    d = $signed({{3{bb[31]}}, bb}) - ($signed({{3{ac[31]}}, ac}) <<< 2);
    meta_next.a = a1;
    meta_next.b = b1;
    meta_next.c = c1;
    if (a1 == '0) begin
      if (b1 != '0) meta_next.st = ST_LINEAR;
      else if (c1 != '0) meta_next.st = ST_NOSOL;
      else meta_next.st = ST_ALLX;
    end else if (d[34]) begin
      meta_next.st = ST_NONE;
    end else if (d == '0) begin
      meta_next.st = ST_DOUBLE;
    end else begin
      meta_next.st = ST_TWO;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      meta <= meta_next;
      disc <= d[34] ? '0 : d[DISC_W-1:0];
    end
  end

endmodule
`default_nettype wire

/* rtl/qes_sqrt.sv */
// Pipelined digit-by-digit square root, one root bit per stage.
// Gives floor(sqrt(disc * 4^FRAC_BITS)). Depends on qes_pkg.
`default_nettype none
module qes_sqrt #(
  parameter int FRAC_BITS = qes_pkg::FRAC_BITS_DEF,
  localparam int SQN = 17 + FRAC_BITS
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       en,
  input  wire logic                       in_valid,
  input  wire qes_pkg::meta_t             meta_in,
  input  wire logic [qes_pkg::DISC_W-1:0] disc,
  output      logic                       out_valid,
  output      qes_pkg::meta_t             meta_out,
  output      logic [SQN-1:0]             root
);
  import qes_pkg::*;

  localparam int RW = SQN + 3;

  logic              v    [SQN];
  meta_t             md   [SQN];
  logic [DISC_W-1:0] dd   [SQN];
  logic [RW-1:0]     rem  [SQN];
  logic [SQN-1:0]    rt   [SQN];

  for (genvar k = 0; k < SQN; k++) begin : g_stage
    logic              cv;
    meta_t             cm;
    logic [DISC_W-1:0] cd;
    logic [RW-1:0]     crem, remsh, trial;
    logic [SQN-1:0]    crt;
    logic [1:0]        pair;
    logic              ge;

    if (k == 0) begin : g_first
      assign cv = in_valid;
      assign cm = meta_in;
      assign cd = disc;
      assign crem = '0;
      assign crt = '0;
    end else begin : g_next
      assign cv = v[k-1];
      assign cm = md[k-1];
      assign cd = dd[k-1];
      assign crem = rem[k-1];
      assign crt = rt[k-1];
    end

    if (k <= 16) begin : g_pair
      assign pair = cd[2*(16-k)+1 -: 2];
    end else begin : g_zero
      assign pair = 2'b00;
    end

    assign remsh = {crem[RW-3:0], pair};
    assign trial = {1'b0, crt, 2'b01};
    assign ge = remsh >= trial;

    always_ff @(posedge clk) begin
      if (rst) v[k] <= 1'b0;
      else if (en) v[k] <= cv;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        md[k] <= cm;
        dd[k] <= cd;
        rem[k] <= ge ? remsh - trial : remsh;
        rt[k] <= {crt[SQN-2:0], ge};
      end
    end
  end

  assign out_valid = v[SQN-1];
  assign meta_out = md[SQN-1];
  assign root = rt[SQN-1];

endmodule
`default_nettype wire

/* rtl/qes_div.sv */
// Pipelined restoring divider with round-to-nearest (ties away from zero)
// and saturation to the root width. Depends on qes_pkg.
`default_nettype none
module qes_div #(
  parameter int FRAC_BITS = qes_pkg::FRAC_BITS_DEF,
  parameter int SIDE_W = 3,
  localparam int NUMW = 19 + FRAC_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire logic                          in_valid,
  input  wire logic signed [NUMW-1:0]        num,
  input  wire logic signed [17:0]            den,
  input  wire logic [SIDE_W-1:0]             side_in,
  output      logic                          out_valid,
  output      logic signed [qes_pkg::ROOT_W-1:0] quot,
  output      logic [SIDE_W-1:0]             side_out
);
  import qes_pkg::*;

  localparam int NW = NUMW + 1;
  localparam int DW = 18;
  localparam logic [63:0] POS_MAX = 64'd8589934591;
  localparam logic [63:0] NEG_MAX = 64'd8589934592;

  logic [NUMW-1:0]   un;
  logic [17:0]       ud;

  logic              v0, neg0;
  logic [NW-1:0]     n0;
  logic [DW-1:0]     d0;
  logic [SIDE_W-1:0] s0;

  logic              v    [NW];
  logic              ng   [NW];
  logic [NW-1:0]     q    [NW];
  logic [DW-1:0]     rem  [NW];
  logic [DW-1:0]     dv   [NW];
  logic [SIDE_W-1:0] sd   [NW];

  logic [63:0]       qx;

  assign un = num[NUMW-1] ? NUMW'(-num) : NUMW'(num);
  assign ud = den[17] ? 18'(-den) : 18'(den);

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (en) v0 <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg0 <= num[NUMW-1] ^ den[17];
      n0 <= {un, 1'b0} + NW'(ud[16:0]);
      d0 <= {ud[16:0], 1'b0};
      s0 <= side_in;
    end
  end

  for (genvar k = 0; k < NW; k++) begin : g_step
    logic              cv, cn;
    logic [NW-1:0]     cq;
    logic [DW-1:0]     crem, cd;
    logic [SIDE_W-1:0] cs;
    logic [DW:0]       sh;
    logic              ge;

    if (k == 0) begin : g_first
      assign cv = v0;
      assign cn = neg0;
      assign cq = n0;
      assign crem = '0;
      assign cd = d0;
      assign cs = s0;
    end else begin : g_next
      assign cv = v[k-1];
      assign cn = ng[k-1];
      assign cq = q[k-1];
      assign crem = rem[k-1];
      assign cd = dv[k-1];
      assign cs = sd[k-1];
    end

    assign sh = {crem, cq[NW-1]};
    assign ge = sh >= {1'b0, cd};

    always_ff @(posedge clk) begin
      if (rst) v[k] <= 1'b0;
      else if (en) v[k] <= cv;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ng[k] <= cn;
        q[k] <= {cq[NW-2:0], ge};
        rem[k] <= ge ? DW'(sh - {1'b0, cd}) : sh[DW-1:0];
        dv[k] <= cd;
        sd[k] <= cs;
      end
    end
  end

  assign qx = {{(64-NW){1'b0}}, q[NW-1]};

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= v[NW-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_out <= sd[NW-1];
      if (ng[NW-1]) begin
        quot <= (qx > NEG_MAX) ? {1'b1, {(ROOT_W-1){1'b0}}} : ROOT_W'(-qx);
      end else begin
        quot <= (qx > POS_MAX) ? {1'b0, {(ROOT_W-1){1'b1}}} : qx[ROOT_W-1:0];
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/qes_checker.sv */
// Port-level checks for quadratic_equation_solver, bound to the top level.
// Depends on qes_pkg.
`default_nettype none
module qes_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              in_ready,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic [2:0]                        status,
  input wire logic signed [qes_pkg::ROOT_W-1:0] root_one,
  input wire logic signed [qes_pkg::ROOT_W-1:0] root_two
);
  import qes_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(root_one) && $stable(root_two)
      && $stable(status))
    else $error("result changed while stalled");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output side");

  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_TWO |-> root_one >= root_two)
    else $error("roots out of order");

  a_same: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_DOUBLE || status == ST_LINEAR) |-> root_one == root_two)
    else $error("single root differs between outputs");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_NONE || status == ST_NOSOL || status == ST_ALLX)
      |-> root_one == '0 && root_two == '0)
    else $error("nonzero root without a real solution");

endmodule

bind quadratic_equation_solver qes_checker u_qes_checker (
  .clk, .rst, .in_ready, .out_valid, .out_ready, .status, .root_one, .root_two
);
`default_nettype wire
